### design/wnet_pkg.sv
// ----------------------------------------------------------------------------
// wnet_pkg: shared types and constants for the weighted nearest entry table
// Field widths, register indexes, operation codes and weight and threshold reset values.
// ----------------------------------------------------------------------------
package wnet_pkg;

  localparam int NUM_FEAT   = 7;
  localparam int FIELD_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 37;
  localparam int THR_W      = 38;
  localparam int OUT_IDX_W  = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 38;
  localparam int FEAT_IDX_W = 3;

  typedef logic [FEAT_IDX_W-1:0] feat_idx_t;
  typedef logic [WEIGHT_W-1:0]   weight_t;
  typedef logic [DIST_W-1:0]     dist_t;

  localparam feat_idx_t FEAT_LAST = feat_idx_t'(NUM_FEAT - 1);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(NUM_FEAT);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam weight_t WEIGHT_RESET [NUM_FEAT] = '{
    16'd1737, 16'd4054, 16'd1158, 16'd1158, 16'd14477, 16'd26640, 16'd57910
  };

  localparam logic signed [THR_W-1:0] THRESHOLD_RESET = 38'sd655;

endpackage

### design/weighted_nearest_entry_table_unit.sv
// ----------------------------------------------------------------------------
// weighted_nearest_entry_table_unit: weighted nearest entry search and insert
// A search scans every stored entry from start to done_o; an empty table skips the scan.
// A new start is taken only once the unit is idle again, which after a stored insert follows
// the row write, one word per cycle; results cannot be stalled.
// One feature word per cycle passes the read port and the shared multiply-square unit.
// Reset restores weights and threshold and empties the table; contents undefined.
// ----------------------------------------------------------------------------
module weighted_nearest_entry_table_unit #(
  parameter int MAX_ENTRIES  = 64,
  parameter int FEATURE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [wnet_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wnet_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  func_i,
  input  logic signed [wnet_pkg::FIELD_W-1:0]   feature_0_i,
  input  logic signed [wnet_pkg::FIELD_W-1:0]   feature_1_i,
  input  logic signed [wnet_pkg::FIELD_W-1:0]   feature_2_i,
  input  logic signed [wnet_pkg::FIELD_W-1:0]   feature_3_i,
  input  logic signed [wnet_pkg::FIELD_W-1:0]   feature_4_i,
  input  logic signed [wnet_pkg::FIELD_W-1:0]   feature_5_i,
  input  logic signed [wnet_pkg::FIELD_W-1:0]   feature_6_i,
  output logic                                  done_o,
  output logic                                  found_o,
  output logic [wnet_pkg::OUT_IDX_W-1:0]        entry_index_o,
  output logic [wnet_pkg::DIST_W-1:0]           distance_o,
  output logic                                  stored_o,
  output logic                                  table_full_o
);
  import wnet_pkg::*;

  localparam int FB     = FEATURE_BITS;
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH  = MAX_ENTRIES * NUM_FEAT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = FB + 18;
  localparam int S_W    = PROD_W - 16;
  localparam int SQ_W   = 2 * FB + 1;
  localparam int ACC_W  = SQ_W + 3;
  localparam int EXT_W  = ACC_W + DIST_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_WRITE
  } state_e;

  state_e                  state_q;
  logic                    func_q;
  logic [FB-1:0]           item_q [NUM_FEAT];
  weight_t                 weight_q [NUM_FEAT];
  logic signed [THR_W-1:0] thr_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [IDX_W-1:0]        ent_q;
  feat_idx_t               feat_q;
  logic                    issue_q;
  dist_t                   best_q;
  logic [IDX_W-1:0]        best_idx_q;

  logic                    done_q;
  logic                    found_q;
  logic [OUT_IDX_W-1:0]    index_q;
  dist_t                   dist_q;
  logic                    stored_q;
  logic                    full_q;

  // table memory and pipeline
  logic [FB-1:0]           mem_q [DEPTH];
  logic                    mem_we;
  logic [FB-1:0]           rdata_q;

  logic                    p1_vld_q, p2_vld_q, p3_vld_q;
  feat_idx_t               p1_feat_q, p2_feat_q, p3_feat_q;
  logic [IDX_W-1:0]        p1_ent_q, p2_ent_q, p3_ent_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SQ_W-1:0]         sq_q;
  logic [ACC_W-1:0]        acc_q;

  logic                    issue_vld;
  logic signed [FIELD_W-1:0] feat_in [NUM_FEAT];
  logic [FB-1:0]           item_in [NUM_FEAT];
  logic signed [FB:0]      diff;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [S_W-1:0]   s_val;
  logic signed [2*S_W-1:0] sq_full;
  logic [ACC_W-1:0]        acc_d;
  logic [EXT_W-1:0]        acc_ext;
  logic [EXT_W-1:0]        dist_max_ext;
  dist_t                   dist_sat;
  logic                    best_upd;
  logic                    found_w;
  logic                    qualifies;
  logic                    do_store;
  logic [CNT_W-1:0]        idx_res;
  logic [CNT_W+OUT_IDX_W-1:0] idx_ext;
  logic                    accept;

  assign feat_in[0] = feature_0_i;
  assign feat_in[1] = feature_1_i;
  assign feat_in[2] = feature_2_i;
  assign feat_in[3] = feature_3_i;
  assign feat_in[4] = feature_4_i;
  assign feat_in[5] = feature_5_i;
  assign feat_in[6] = feature_6_i;

  always_comb begin
    logic [FB+FIELD_W-1:0] wide;
    for (int i = 0; i < NUM_FEAT; i++) begin
      wide       = {{FB{feat_in[i][FIELD_W-1]}}, feat_in[i]};
      item_in[i] = wide[FB-1:0];
    end
  end

  assign accept    = start && !busy;
  assign issue_vld = (state_q == ST_SCAN) && issue_q;
  assign mem_we    = (state_q == ST_WRITE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= item_q[feat_q];
    end
    rdata_q <= mem_q[addr_q];
  end

  // shared subtract, multiply, square and accumulate unit
  always_comb begin
    diff    = $signed({item_q[p1_feat_q][FB-1], item_q[p1_feat_q]})
              - $signed({rdata_q[FB-1], rdata_q});
    prod_d  = diff * $signed({1'b0, weight_q[p1_feat_q]});
    s_val   = prod_q[PROD_W-1:16];
    sq_full = s_val * s_val;
    acc_d   = ((p3_feat_q == '0) ? '0 : acc_q) + ACC_W'(sq_q);
    acc_ext = EXT_W'(acc_d);
    dist_max_ext = {{ACC_W{1'b0}}, {DIST_W{1'b1}}};
    dist_sat = (acc_ext > dist_max_ext) ? dist_max_ext[DIST_W-1:0]
                                        : acc_ext[DIST_W-1:0];
    best_upd = p3_vld_q && (p3_feat_q == FEAT_LAST)
               && ((p3_ent_q == '0) || (dist_sat < best_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= issue_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_feat_q <= feat_q;
    p1_ent_q  <= ent_q;
    p2_feat_q <= p1_feat_q;
    p2_ent_q  <= p1_ent_q;
    p3_feat_q <= p2_feat_q;
    p3_ent_q  <= p2_ent_q;
    prod_q    <= prod_d;
    sq_q      <= sq_full[SQ_W-1:0];
    if (p3_vld_q) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    found_w   = (cnt_q != '0);
    qualifies = !found_w || ($signed({1'b0, best_q}) > thr_q);
    do_store  = (func_q == FUNC_INSERT) && qualifies
                && (cnt_q != CNT_W'(MAX_ENTRIES));
    idx_res   = do_store ? cnt_q : CNT_W'(best_idx_q);
    idx_ext   = {{OUT_IDX_W{1'b0}}, idx_res};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      func_q     <= FUNC_INSERT;
      weight_q   <= WEIGHT_RESET;
      thr_q      <= THRESHOLD_RESET;
      cnt_q      <= '0;
      addr_q     <= '0;
      ent_q      <= '0;
      feat_q     <= '0;
      issue_q    <= 1'b0;
      best_q     <= '0;
      best_idx_q <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      index_q    <= '0;
      dist_q     <= '0;
      stored_q   <= 1'b0;
      full_q     <= 1'b0;
    end else begin
      done_q <= (state_q == ST_FINISH);
      if (cfg_we_i) begin
        if (cfg_index_i < REG_THRESHOLD) begin
          weight_q[cfg_index_i[FEAT_IDX_W-1:0]] <= cfg_data_i[WEIGHT_W-1:0];
        end else if (cfg_index_i == REG_THRESHOLD) begin
          thr_q <= $signed(cfg_data_i[THR_W-1:0]);
        end
      end
      if (best_upd) begin
        best_q     <= dist_sat;
        best_idx_q <= p3_ent_q;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q     <= func_i;
            item_q     <= item_in;
            best_q     <= '0;
            best_idx_q <= '0;
            addr_q     <= '0;
            ent_q      <= '0;
            feat_q     <= '0;
            issue_q    <= 1'b1;
            state_q    <= (cnt_q == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue_q) begin
            addr_q <= addr_q + 1'b1;
            if (feat_q == FEAT_LAST) begin
              feat_q <= '0;
              if (CNT_W'(ent_q) == cnt_q - 1'b1) begin
                issue_q <= 1'b0;
              end else begin
                ent_q <= ent_q + 1'b1;
              end
            end else begin
              feat_q <= feat_q + 1'b1;
            end
          end else if (!p1_vld_q && !p2_vld_q && !p3_vld_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          found_q  <= found_w;
          index_q  <= idx_ext[OUT_IDX_W-1:0];
          dist_q   <= best_q;
          stored_q <= do_store;
          full_q   <= (func_q == FUNC_INSERT) && qualifies && !do_store;
          feat_q   <= '0;
          if (do_store) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_WRITE;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_WRITE: begin
          addr_q <= addr_q + 1'b1;
          feat_q <= feat_q + 1'b1;
          if (feat_q == FEAT_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign entry_index_o = index_q;
  assign distance_o    = dist_q;
  assign stored_o      = stored_q;
  assign table_full_o  = full_q;

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FINISH))
    else $error("result strobe without a finished search");

  a_stored_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(stored_o && table_full_o))
    else $error("transaction both stored and refused");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accepted transaction");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (distance_o == '0))
    else $error("nonzero distance on empty table");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for weighted_nearest_entry_table_unit
// Sends insert and query transactions through the start/busy port and checks
// every done_o strobe against a behavioral copy of the table. The copy keeps
// its own weights, threshold and stored rows. A directed opening covers the
// empty table, ties, merges and zero and full scale weights. Random phases
// follow, each with its own weights, threshold and sender idling, and they
// run on into a full table.
// ----------------------------------------------------------------------------
module tb_top;
  import wnet_pkg::*;

  localparam int     MAX_ENTRIES = 64;
  localparam int     UPPER_W     = CFG_DATA_W - WEIGHT_W;
  localparam int     TAIL_CYCLES = 7 * MAX_ENTRIES + 5 + 7 + 20;
  localparam longint DIST_CEIL   = (longint'(1) << DIST_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = '0;
  localparam weight_t MIXED_WEIGHTS [NUM_FEAT] = '{
    16'hffff, 16'h0000, 16'h0001, 16'h8000, 16'hffff, 16'h0000, 16'hffff
  };

  typedef enum int {W_RESET, W_RANDOM, W_FULL_SCALE, W_MIXED} weight_mode_e;

  typedef struct packed {
    logic                              func;
    logic [NUM_FEAT-1:0][FIELD_W-1:0]  feat;
  } item_t;

  typedef struct packed {
    logic                  found;
    logic [OUT_IDX_W-1:0]  entry_index;
    dist_t                 distance;
    logic                  stored;
    logic                  table_full;
  } result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   start       = 1'b0;
  logic                   busy;
  item_t                  drv_item    = '0;
  logic                   done_o;
  logic                   found_o;
  logic [OUT_IDX_W-1:0]   entry_index_o;
  logic [DIST_W-1:0]      distance_o;
  logic                   stored_o;
  logic                   table_full_o;

  // behavioral copy of the table
  weight_t                    weight_reg [NUM_FEAT];
  longint                     merge_thr;
  logic signed [FIELD_W-1:0]  entry_store [MAX_ENTRIES][NUM_FEAT];
  int                         entry_count;

  item_t    item_fifo [$];
  result_t  lookup_results_due [$];
  int       idle_pct   = 0;
  int       fail_count = 0;

  weighted_nearest_entry_table_unit #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .FEATURE_BITS(FIELD_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .func_i       (drv_item.func),
    .feature_0_i  (drv_item.feat[0]),
    .feature_1_i  (drv_item.feat[1]),
    .feature_2_i  (drv_item.feat[2]),
    .feature_3_i  (drv_item.feat[3]),
    .feature_4_i  (drv_item.feat[4]),
    .feature_5_i  (drv_item.feat[5]),
    .feature_6_i  (drv_item.feat[6]),
    .done_o       (done_o),
    .found_o      (found_o),
    .entry_index_o(entry_index_o),
    .distance_o   (distance_o),
    .stored_o     (stored_o),
    .table_full_o (table_full_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void enqueue(item_t it);
    item_fifo.insert(item_fifo.size(), it);
  endfunction

  function automatic dist_t weighted_distance(item_t it, int slot);
    longint acc;
    longint d;
    longint s;
    acc = 0;
    for (int f = 0; f < NUM_FEAT; f++) begin
      d = longint'($signed(it.feat[f])) - longint'(entry_store[slot][f]);
      d = d * longint'(weight_reg[f]);
      s = d >>> 16;
      acc += s * s;
    end
    if (acc > DIST_CEIL) acc = DIST_CEIL;
    return dist_t'(acc);
  endfunction

  function automatic result_t predict_lookup(item_t it);
    result_t r;
    dist_t   best;
    dist_t   d;
    int      best_slot;
    logic    qualifies;
    r = '0;
    best = '0;
    best_slot = 0;
    r.found = (entry_count > 0);
    for (int m = 0; m < entry_count; m++) begin
      d = weighted_distance(it, m);
      if (m == 0 || d < best) begin
        best = d;
        best_slot = m;
      end
    end
    r.entry_index = OUT_IDX_W'(best_slot);
    r.distance = best;
    if (it.func == FUNC_INSERT) begin
      qualifies = !r.found || (longint'(best) > merge_thr);
      if (qualifies) begin
        if (entry_count >= MAX_ENTRIES) begin
          r.table_full = 1'b1;
        end else begin
          for (int f = 0; f < NUM_FEAT; f++) entry_store[entry_count][f] = it.feat[f];
          r.entry_index = OUT_IDX_W'(entry_count);
          r.stored = 1'b1;
          entry_count++;
        end
      end
    end
    return r;
  endfunction

  function automatic item_t uniform_item(logic fn, logic [FIELD_W-1:0] v);
    item_t it;
    it.func = fn;
    for (int f = 0; f < NUM_FEAT; f++) it.feat[f] = v;
    return it;
  endfunction

  // perturbed copies of stored rows, plus random and extreme vectors
  function automatic item_t random_item();
    item_t             it;
    int                kind;
    int                slot;
    logic [FIELD_W-1:0] delta;
    it.func = ($urandom_range(0, 1) != 0) ? FUNC_QUERY : FUNC_INSERT;
    kind = $urandom_range(0, 99);
    slot = (entry_count > 0) ? $urandom_range(0, entry_count - 1) : 0;
    for (int f = 0; f < NUM_FEAT; f++) begin
      if (kind < 45 && entry_count > 0) begin
        delta = (kind < 12) ? '0 : FIELD_W'($urandom_range(0, 64)) - 16'd32;
        it.feat[f] = entry_store[slot][f] + delta;
      end else if (kind < 85) begin
        it.feat[f] = FIELD_W'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: it.feat[f] = 16'h8000;
          1: it.feat[f] = 16'h7fff;
          2: it.feat[f] = 16'h0000;
          default: it.feat[f] = 16'hffff;
        endcase
      end
    end
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx < NUM_FEAT) weight_reg[idx] = data[WEIGHT_W-1:0];
    else if (idx == REG_THRESHOLD) merge_thr = longint'($signed(data[THR_W-1:0]));
  endtask

  task automatic apply_settings(input weight_mode_e mode, input longint thr);
    weight_t w;
    int      r;
    for (int f = 0; f < NUM_FEAT; f++) begin
      case (mode)
        W_RESET:      w = WEIGHT_RESET[f];
        W_FULL_SCALE: w = '1;
        W_MIXED:      w = MIXED_WEIGHTS[f];
        default: begin
          r = $urandom_range(0, 99);
          w = (r < 15) ? '0 : (r < 30) ? '1 : WEIGHT_W'($urandom);
        end
      endcase
      write_reg(REG_WEIGHT_0 + CFG_IDX_W'(f), {UPPER_W'($urandom), w});
    end
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    // unmapped index, must leave everything as it is
    write_reg(CFG_IDX_W'($urandom_range(REG_THRESHOLD + 1, 2 ** CFG_IDX_W - 1)),
              CFG_DATA_W'({$urandom, $urandom}));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (item_fifo.size() != 0 || start || busy || lookup_results_due.size() != 0);
  endtask

  task automatic run_random(input weight_mode_e mode, input longint thr, input int n,
                            input int idle);
    apply_settings(mode, thr);
    idle_pct = idle;
    @(negedge clk_i);
    repeat (n) enqueue(random_item());
    wait_idle();
  endtask

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (fail_count < 10) $display("mismatch %s: expected %0d got %0d", what, want, got);
    fail_count++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        lookup_results_due.insert(lookup_results_due.size(), predict_lookup(drv_item));
      if (!start || !busy) begin
        if (item_fifo.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_item <= item_fifo.pop_front();
          start    <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (lookup_results_due.size() == 0) begin
        report_mismatch("result without transaction, distance", 0, distance_o);
      end else begin
        want = lookup_results_due.pop_front();
        if (found_o !== want.found) report_mismatch("found", want.found, found_o);
        if (entry_index_o !== want.entry_index)
          report_mismatch("entry_index", want.entry_index, entry_index_o);
        if (distance_o !== want.distance) report_mismatch("distance", want.distance, distance_o);
        if (stored_o !== want.stored) report_mismatch("stored", want.stored, stored_o);
        if (table_full_o !== want.table_full)
          report_mismatch("table_full", want.table_full, table_full_o);
      end
    end
  end

  initial begin
    item_t it;
    for (int f = 0; f < NUM_FEAT; f++) weight_reg[f] = WEIGHT_RESET[f];
    merge_thr = longint'(THRESHOLD_RESET);
    entry_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset weights and threshold: empty table, merge, far inserts
    @(negedge clk_i);
    enqueue(uniform_item(FUNC_QUERY, 16'h7fff));
    enqueue(uniform_item(FUNC_INSERT, 16'h8000));
    enqueue(uniform_item(FUNC_INSERT, 16'h7fff));
    enqueue(uniform_item(FUNC_QUERY, 16'h8000));
    enqueue(uniform_item(FUNC_QUERY, 16'h7fff));
    enqueue(uniform_item(FUNC_INSERT, 16'h8000));
    enqueue(uniform_item(FUNC_QUERY, 16'h0000));
    enqueue(uniform_item(FUNC_INSERT, 16'h5555));
    enqueue(uniform_item(FUNC_INSERT, 16'haaaa));
    it = uniform_item(FUNC_QUERY, 16'h5555);
    it.feat[6] = 16'h5556;
    enqueue(it);
    wait_idle();

    // negative threshold and zero weights: duplicates, ties, ignored features
    apply_settings(W_MIXED, -1);
    @(negedge clk_i);
    enqueue(uniform_item(FUNC_INSERT, 16'h8000));
    enqueue(uniform_item(FUNC_QUERY, 16'h8000));
    it = uniform_item(FUNC_INSERT, 16'h8000);
    for (int f = 1; f < NUM_FEAT; f += 2) it.feat[f] = 16'h7fff;
    enqueue(it);
    it.func = FUNC_QUERY;
    it.feat[1] = 16'h1234;
    it.feat[5] = 16'h0000;
    enqueue(it);
    enqueue(uniform_item(FUNC_INSERT, 16'h0000));
    enqueue(uniform_item(FUNC_QUERY, 16'hffff));
    wait_idle();

    run_random(W_RANDOM, DIST_CEIL, 300, 0);
    run_random(W_RESET, longint'($urandom_range(0, 2 ** 28)), 250, 51);
    run_random(W_RANDOM, -1, 150, 33);
    run_random(W_FULL_SCALE, 0, 150, 0);
    run_random(W_RANDOM, longint'({$urandom, $urandom}) & ((longint'(1) << 36) - 1), 200, 51);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && lookup_results_due.size() == 0) begin
      $display("[weighted_nearest_entry_table_unit] OK");
    end else begin
      $display("[weighted_nearest_entry_table_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #25000000;
    $display("[weighted_nearest_entry_table_unit] ERROR");
    $finish;
  end

endmodule

### filelist.f
design/wnet_pkg.sv
design/weighted_nearest_entry_table_unit.sv
tb/tb_top.sv
